@@ hw/rtl/skr_pkg.sv @@
// shared types, codes and constants for the sequence-keyed match ring
package skr_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam int SEQ_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int DELTA_W  = 8;
    localparam int CNT_W    = 32;
    localparam int SKEW_W   = 40;
    localparam int ENTRY_W  = SEQ_W + HANDLE_W;

    localparam logic [DELTA_W-1:0] MAX_SKEW_RESET = 8'd3;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_STATS  = 2'd2;

    // match kind codes
    localparam logic [1:0] KIND_EXACT    = 2'd0;
    localparam logic [1:0] KIND_FALLBACK = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;
    localparam logic [1:0] KIND_LATEST   = 2'd3;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] payload_handle;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] match_handle;
        logic [SEQ_W-1:0]    match_seq;
        logic [1:0]          match_kind;
        logic [DELTA_W-1:0]  match_delta;
        logic [CNT_W-1:0]    exact_total;
        logic [CNT_W-1:0]    fallback_total;
        logic [CNT_W-1:0]    miss_total;
        logic [SKEW_W-1:0]   skew_total;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic insert;
        logic scan_rd;
        logic scan_cmp;
        logic finish;
        logic stats;
    } ctl_cmd_t;

endpackage

@@ hw/rtl/skr_ram.sv @@
// generic single-write, single-read ram with registered read data
module skr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/skr_ctrl.sv @@
// controller state machine: sequences insert, scan and stats operations
module skr_ctrl #(
    parameter int RING_DEPTH = skr_pkg::RING_DEPTH_DEF,
    localparam int IDX_W = $clog2(RING_DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       req_type,
    output logic             busy,
    output skr_pkg::ctl_cmd_t cmd,
    output logic [IDX_W-1:0] scan_addr,
    output logic [IDX_W-1:0] cmp_addr
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INSERT = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LAST   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_STATS  = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             cmp_pending_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load      = 1'b1;
                    scan_idx_next = '0;
                    case (req_type)
                        skr_pkg::REQ_INSERT: state_next = S_INSERT;
                        skr_pkg::REQ_LOOKUP: state_next = S_SCAN;
                        skr_pkg::REQ_STATS:  state_next = S_STATS;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next    = S_LAST;
                    scan_idx_next = '0;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_STATS:
            begin
                cmd.stats  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.scan_cmp = cmp_pending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scan_idx_reg    <= '0;
            cmp_pending_reg <= 1'b0;
            cmp_idx_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_idx_reg    <= scan_idx_next;
            cmp_pending_reg <= (state_reg == S_SCAN);
            cmp_idx_reg     <= scan_idx_reg;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign scan_addr = scan_idx_reg;
    assign cmp_addr  = cmp_idx_reg;

    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_cmp |-> $past(cmd.scan_rd))
        else $error("compare without a read in the previous cycle");

    a_no_rd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !cmd.scan_rd && !cmd.scan_cmp)
        else $error("scan activity while idle");

    a_finish_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> $past(state_reg) == S_LAST)
        else $error("finish without a completed scan");

endmodule

@@ hw/rtl/skr_dpath.sv @@
// datapath: entry memory, valid bits, scan comparators, counters, result register
module skr_dpath #(
    parameter int RING_DEPTH = skr_pkg::RING_DEPTH_DEF,
    localparam int IDX_W = $clog2(RING_DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [skr_pkg::DELTA_W-1:0]    cfg_wdata,
    input  skr_pkg::req_t                  req,
    input  skr_pkg::ctl_cmd_t              cmd,
    input  logic [IDX_W-1:0]               scan_addr,
    input  logic [IDX_W-1:0]               cmp_addr,
    output logic                           done,
    output skr_pkg::rsp_t                  rsp
);

    localparam int SEQ_W    = skr_pkg::SEQ_W;
    localparam int HANDLE_W = skr_pkg::HANDLE_W;
    localparam int DELTA_W  = skr_pkg::DELTA_W;
    localparam int CNT_W    = skr_pkg::CNT_W;
    localparam int SKEW_W   = skr_pkg::SKEW_W;
    localparam int ENTRY_W  = skr_pkg::ENTRY_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    skr_pkg::req_t          req_reg;
    logic [DELTA_W-1:0]     max_skew_reg;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [RING_DEPTH-1:0]  valid_reg, valid_next;

    // scan results
    logic                   best_got_reg, best_got_next;
    logic [SEQ_W-1:0]       top_seq_reg, top_seq_next;
    logic [HANDLE_W-1:0]    best_handle_reg, best_handle_next;
    logic [DELTA_W-1:0]     best_delta_reg, best_delta_next;
    logic                   exact_got_reg, exact_got_next;
    logic [IDX_W-1:0]       exact_idx_reg, exact_idx_next;
    logic [HANDLE_W-1:0]    exact_handle_reg, exact_handle_next;

    logic [CNT_W-1:0]       exact_cnt_reg, exact_cnt_next;
    logic [CNT_W-1:0]       fb_cnt_reg, fb_cnt_next;
    logic [CNT_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic [SKEW_W-1:0]      skew_acc_reg, skew_acc_next;

    logic                   done_reg, done_next;
    skr_pkg::rsp_t          rsp_reg, rsp_next;

    logic [ENTRY_W-1:0]     rd_data;
    logic [SEQ_W-1:0]       ent_seq;
    logic [HANDLE_W-1:0]    ent_handle;
    logic                   ent_valid;
    logic                   latest_mode;
    logic                   seq_above;
    logic [SEQ_W-1:0]       seq_gap;
    logic                   in_window;
    logic [DELTA_W-1:0]     dist_lo;

    skr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.insert),
        .waddr (head_reg),
        .wdata ({req_reg.seq, req_reg.payload_handle}),
        .re    (cmd.scan_rd),
        .raddr (scan_addr),
        .rdata (rd_data)
    );

    assign ent_seq     = rd_data[ENTRY_W-1:HANDLE_W];
    assign ent_handle  = rd_data[HANDLE_W-1:0];
    assign ent_valid   = valid_reg[cmp_addr];
    assign latest_mode = (req_reg.seq == '0);
    assign seq_above   = (ent_seq > req_reg.seq);
    assign seq_gap     = seq_above ? (ent_seq - req_reg.seq) : (req_reg.seq - ent_seq);
    assign dist_lo     = seq_gap[DELTA_W-1:0];
    assign in_window   = (seq_gap[SEQ_W-1:DELTA_W] == '0) && (dist_lo <= max_skew_reg);

    // scan compare and ring bookkeeping
    always_comb
    begin
        valid_next        = valid_reg;
        head_next         = head_reg;
        best_got_next     = best_got_reg;
        top_seq_next      = top_seq_reg;
        best_handle_next  = best_handle_reg;
        best_delta_next   = best_delta_reg;
        exact_got_next    = exact_got_reg;
        exact_idx_next    = exact_idx_reg;
        exact_handle_next = exact_handle_reg;

        if (cmd.load)
        begin
            best_got_next    = 1'b0;
            top_seq_next     = '0;
            best_handle_next = '0;
            best_delta_next  = '0;
            exact_got_next   = 1'b0;
        end

        if (cmd.insert)
        begin
            valid_next[head_reg] = 1'b1;
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end

        if (cmd.scan_cmp && ent_valid)
        begin
            if (latest_mode)
            begin
                if (ent_seq > top_seq_reg)
                begin
                    best_got_next    = 1'b1;
                    top_seq_next     = ent_seq;
                    best_handle_next = ent_handle;
                end
            end
            else
            begin
                // stale entry below the window
                if (!seq_above && !in_window)
                begin
                    valid_next[cmp_addr] = 1'b0;
                end
                if (ent_seq == req_reg.seq && !exact_got_reg)
                begin
                    exact_got_next    = 1'b1;
                    exact_idx_next    = cmp_addr;
                    exact_handle_next = ent_handle;
                end
                if (in_window && (!best_got_reg || dist_lo < best_delta_reg ||
                    (dist_lo == best_delta_reg && ent_seq > top_seq_reg)))
                begin
                    best_got_next    = 1'b1;
                    top_seq_next     = ent_seq;
                    best_handle_next = ent_handle;
                    best_delta_next  = dist_lo;
                end
            end
        end

        // an exact match is consumed
        if (cmd.finish && !latest_mode && exact_got_reg)
        begin
            valid_next[exact_idx_reg] = 1'b0;
        end
    end

    // result word and statistics
    always_comb
    begin
        exact_cnt_next = exact_cnt_reg;
        fb_cnt_next    = fb_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        skew_acc_next  = skew_acc_reg;
        done_next      = 1'b0;
        rsp_next       = '0;
        rsp_next.match_kind = skr_pkg::KIND_NONE;

        if (cmd.finish)
        begin
            done_next = 1'b1;
            if (latest_mode)
            begin
                rsp_next.found        = best_got_reg;
                rsp_next.match_handle = best_handle_reg;
                rsp_next.match_seq    = top_seq_reg;
                rsp_next.match_kind   = skr_pkg::KIND_LATEST;
            end
            else if (exact_got_reg)
            begin
                rsp_next.found        = 1'b1;
                rsp_next.match_handle = exact_handle_reg;
                rsp_next.match_seq    = req_reg.seq;
                rsp_next.match_kind   = skr_pkg::KIND_EXACT;
                exact_cnt_next        = exact_cnt_reg + 1'b1;
            end
            else if (best_got_reg)
            begin
                rsp_next.found        = 1'b1;
                rsp_next.match_handle = best_handle_reg;
                rsp_next.match_seq    = top_seq_reg;
                rsp_next.match_kind   = skr_pkg::KIND_FALLBACK;
                rsp_next.match_delta  = best_delta_reg;
                fb_cnt_next           = fb_cnt_reg + 1'b1;
                skew_acc_next         = skew_acc_reg + SKEW_W'(best_delta_reg);
            end
            else
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
        else if (cmd.stats)
        begin
            done_next               = 1'b1;
            rsp_next.exact_total    = exact_cnt_reg;
            rsp_next.fallback_total = fb_cnt_reg;
            rsp_next.miss_total     = miss_cnt_reg;
            rsp_next.skew_total     = skew_acc_reg;
            exact_cnt_next          = '0;
            fb_cnt_next             = '0;
            miss_cnt_next           = '0;
            skew_acc_next           = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_skew_reg  <= skr_pkg::MAX_SKEW_RESET;
            head_reg      <= '0;
            valid_reg     <= '0;
            best_got_reg  <= 1'b0;
            exact_got_reg <= 1'b0;
            exact_cnt_reg <= '0;
            fb_cnt_reg    <= '0;
            miss_cnt_reg  <= '0;
            skew_acc_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_skew_reg <= cfg_wdata;
            end
            head_reg      <= head_next;
            valid_reg     <= valid_next;
            best_got_reg  <= best_got_next;
            exact_got_reg <= exact_got_next;
            exact_cnt_reg <= exact_cnt_next;
            fb_cnt_reg    <= fb_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            skew_acc_reg  <= skew_acc_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        top_seq_reg      <= top_seq_next;
        best_handle_reg  <= best_handle_next;
        best_delta_reg   <= best_delta_next;
        exact_idx_reg    <= exact_idx_next;
        exact_handle_reg <= exact_handle_next;
        rsp_reg          <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.finish || cmd.stats))
        else $error("result strobe without finish or stats");

    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> valid_reg[$past(head_reg)])
        else $error("inserted slot not marked valid");

endmodule

@@ hw/rtl/seq_keyed_match_ring.sv @@
// top level of the sequence-keyed match ring
//
// usage: drive a request word on req and raise start; it is taken at a rising
// edge where start is high and busy is low. an insert gives no result. a stats
// request puts its result word on rsp, marked by done, in the cycle in which
// busy falls. a lookup walks the whole ring one entry per cycle through the
// single read port of the entry memory, and done then marks the result for
// one cycle. done is a one-cycle strobe: the receiver cannot stall it and must
// take the word when it shows. a request with req_type 3 is taken and dropped.
// max_skew is written through cfg_we / cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// the entry memory needs no clearing pass: per-slot valid bits are cleared by
// reset and gate every compare of the memory read data.
module seq_keyed_match_ring #(
    parameter int RING_DEPTH = skr_pkg::RING_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request word
    input  logic                        start,
    output logic                        busy,
    input  skr_pkg::req_t               req,
    // result word, one-cycle strobe
    output logic                        done,
    output skr_pkg::rsp_t               rsp,
    // max_skew register write
    input  logic                        cfg_we,
    input  logic [skr_pkg::DELTA_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(RING_DEPTH);

    skr_pkg::ctl_cmd_t cmd;
    logic [IDX_W-1:0]  scan_addr;
    logic [IDX_W-1:0]  cmp_addr;

    // sequencer: decodes the request type and steps the ring scan
    skr_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req.req_type),
        .busy      (busy),
        .cmd       (cmd),
        .scan_addr (scan_addr),
        .cmp_addr  (cmp_addr)
    );

    // entries, purge / exact / fallback / latest compare, counters and result register
    skr_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .scan_addr (scan_addr),
        .cmp_addr  (cmp_addr),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

@@ sim/tb.sv @@
// testbench for seq_keyed_match_ring: directed and random request words against a ring predictor
module tb;
    import skr_pkg::*;

    localparam int DEPTH       = RING_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = DEPTH + 8;   // covers an insert still in flight
    localparam int PHASE_WORDS = 100;

    // dut ports, the inputs all known from time zero
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    req_t               req       = '0;
    logic               done;
    rsp_t               rsp;
    logic               cfg_we    = 1'b0;
    logic [DELTA_W-1:0] cfg_wdata = '0;

    // predictor copy of the ring, its counters and the skew register
    logic              ring_valid [DEPTH];
    logic [SEQ_W-1:0]  ring_seq   [DEPTH];
    logic [HANDLE_W-1:0] ring_handle [DEPTH];
    int                ring_head;
    logic [CNT_W-1:0]  exact_cnt, fallback_cnt, miss_cnt;
    logic [SKEW_W-1:0] skew_sum;
    logic [DELTA_W-1:0] skew_cfg;

    // response words still owed by the dut, oldest first
    rsp_t pending_rsp[$];

    int  mismatch_count = 0;
    int  words_sent     = 0;
    int  words_dropped  = 0;
    int  rsp_checked    = 0;
    int  skew_writes    = 0;
    int  cycle_count    = 0;
    bit  burst_mode     = 1'b0;

    seq_keyed_match_ring dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog, the only way out besides the normal end
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still owed", cycle_count,
                     pending_rsp.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // works out the response a request word causes and advances the ring state
    // returns 0 for words that give no response (insert, unused code)
    function automatic bit predict_response(input req_t w, output rsp_t r);
        logic [SEQ_W-1:0]    want;
        logic [SEQ_W-1:0]    oldest;
        logic [SEQ_W-1:0]    seq_gap;
        logic [SEQ_W-1:0]    top_seq;
        logic [SEQ_W-1:0]    best_dist;
        logic [HANDLE_W-1:0] best_handle;
        bit                  got;
        r    = '0;
        want = w.seq;
        case (w.req_type)
            REQ_INSERT:
            begin
                ring_valid[ring_head]  = 1'b1;
                ring_seq[ring_head]    = want;
                ring_handle[ring_head] = w.payload_handle;
                ring_head = (ring_head + 1) % DEPTH;
                return 1'b0;
            end
            REQ_STATS:
            begin
                // totals come out before the clear
                r.match_kind     = KIND_NONE;
                r.exact_total    = exact_cnt;
                r.fallback_total = fallback_cnt;
                r.miss_total     = miss_cnt;
                r.skew_total     = skew_sum;
                exact_cnt    = '0;
                fallback_cnt = '0;
                miss_cnt     = '0;
                skew_sum     = '0;
                return 1'b1;
            end
            REQ_LOOKUP:
            begin
                // sequence zero: newest nonzero entry, first index wins a tie, nothing consumed
                if (want == '0)
                begin
                    got         = 1'b0;
                    top_seq     = '0;
                    best_handle = '0;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (ring_valid[i] && ring_seq[i] > top_seq)
                        begin
                            top_seq     = ring_seq[i];
                            best_handle = ring_handle[i];
                            got         = 1'b1;
                        end
                    end
                    r.found        = got;
                    r.match_handle = best_handle;
                    r.match_seq    = top_seq;
                    r.match_kind   = KIND_LATEST;
                    return 1'b1;
                end
                // stale entries leave the ring before any match
                if (want > SEQ_W'(skew_cfg))
                begin
                    oldest = want - SEQ_W'(skew_cfg);
                    for (int i = 0; i < DEPTH; i++)
                        if (ring_valid[i] && ring_seq[i] < oldest)
                            ring_valid[i] = 1'b0;
                end
                // exact hit is consumed, lowest index first
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (ring_valid[i] && ring_seq[i] == want)
                    begin
                        ring_valid[i]  = 1'b0;
                        exact_cnt      = exact_cnt + 1'b1;
                        r.found        = 1'b1;
                        r.match_handle = ring_handle[i];
                        r.match_seq    = want;
                        r.match_kind   = KIND_EXACT;
                        return 1'b1;
                    end
                end
                // closest within the window, larger sequence on a tie, kept in the ring
                got         = 1'b0;
                top_seq     = '0;
                best_dist   = '0;
                best_handle = '0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (ring_valid[i])
                    begin
                        seq_gap = (ring_seq[i] > want) ? ring_seq[i] - want
                                                       : want - ring_seq[i];
                        if (seq_gap <= SEQ_W'(skew_cfg) &&
                            (!got || seq_gap < best_dist ||
                             (seq_gap == best_dist && ring_seq[i] > top_seq)))
                        begin
                            got         = 1'b1;
                            best_dist   = seq_gap;
                            top_seq     = ring_seq[i];
                            best_handle = ring_handle[i];
                        end
                    end
                end
                if (got)
                begin
                    fallback_cnt   = fallback_cnt + 1'b1;
                    skew_sum       = skew_sum + SKEW_W'(best_dist);
                    r.found        = 1'b1;
                    r.match_handle = best_handle;
                    r.match_seq    = top_seq;
                    r.match_kind   = KIND_FALLBACK;
                    r.match_delta  = best_dist[DELTA_W-1:0];
                end
                else
                begin
                    miss_cnt     = miss_cnt + 1'b1;
                    r.match_kind = KIND_NONE;
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // response checker: done is a one-cycle strobe, sampled at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response word at cycle %0d: found=%0b kind=%0d",
                             cycle_count, rsp.found, rsp.match_kind);
            end
            else
            begin
                rsp_t exp_rsp;
                exp_rsp = pending_rsp.pop_front();
                rsp_checked++;
                if (rsp !== exp_rsp)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  exp f=%0b h=%h s=%h k=%0d d=%0d tot=%0d/%0d/%0d/%0d",
                                 exp_rsp.found, exp_rsp.match_handle, exp_rsp.match_seq,
                                 exp_rsp.match_kind, exp_rsp.match_delta, exp_rsp.exact_total,
                                 exp_rsp.fallback_total, exp_rsp.miss_total,
                                 exp_rsp.skew_total);
                        $display("  got f=%0b h=%h s=%h k=%0d d=%0d tot=%0d/%0d/%0d/%0d",
                                 rsp.found, rsp.match_handle, rsp.match_seq, rsp.match_kind,
                                 rsp.match_delta, rsp.exact_total, rsp.fallback_total,
                                 rsp.miss_total, rsp.skew_total);
                    end
                end
            end
        end
    end

    // sends one request word; called at a rising edge, returns at the edge that took it
    // start is left high so a back-to-back word never drops it within one step
    task automatic issue_word(input req_t w);
        int   gap;
        rsp_t exp_rsp;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (w.req_type != REQ_INSERT && w.req_type != REQ_LOOKUP && w.req_type != REQ_STATS)
            words_dropped++;
        if (predict_response(w, exp_rsp))
            pending_rsp.push_back(exp_rsp);
    endtask

    task automatic send_req(input logic [1:0] kind, input logic [SEQ_W-1:0] s,
                            input logic [HANDLE_W-1:0] h);
        req_t w;
        w.req_type       = kind;
        w.seq            = s;
        w.payload_handle = h;
        issue_word(w);
    endtask

    // lets every owed word arrive, then waits out a trailing insert
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_skew(input logic [DELTA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        skew_cfg  = value;
        skew_writes++;
    endtask

    // lookups and stats before anything was inserted, plus the unused code
    task automatic test_empty_ring();
        send_req(REQ_LOOKUP, 32'd5, 16'h1234);
        send_req(REQ_LOOKUP, 32'd0, 16'h0000);
        send_req(REQ_STATS, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(2'd3, 32'hA5A5_A5A5, 16'h5A5A);
    endtask

    // latest, exact, fallback with a tie, purge to a miss, duplicates, stats
    task automatic test_match_kinds();
        send_req(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(REQ_INSERT, 32'd0, 16'h0000);
        send_req(REQ_INSERT, 32'd100, 16'h0001);
        send_req(REQ_INSERT, 32'd102, 16'h0002);
        send_req(REQ_INSERT, 32'd98, 16'h0003);
        send_req(REQ_LOOKUP, 32'd0, 16'h0);        // newest is the all-ones sequence
        send_req(REQ_LOOKUP, 32'd100, 16'h0);      // exact, consumed
        send_req(REQ_LOOKUP, 32'd100, 16'h0);      // 98 and 102 tie, larger wins
        send_req(REQ_LOOKUP, 32'd110, 16'h0);      // purge drops 98 and 102, miss
        send_req(REQ_INSERT, 32'd500, 16'hAAAA);
        send_req(REQ_INSERT, 32'd500, 16'h5555);
        send_req(REQ_LOOKUP, 32'd500, 16'h0);      // duplicate, lower slot taken
        send_req(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0);
        send_req(REQ_STATS, 32'd0, 16'h0);
    endtask

    // window at both ends of the register range
    task automatic test_skew_window();
        write_skew(8'd0);
        send_req(REQ_INSERT, 32'd1000, 16'h0100);
        send_req(REQ_LOOKUP, 32'd1001, 16'h0);     // zero window purges it
        write_skew(8'd255);
        send_req(REQ_INSERT, 32'd5000, 16'h0500);
        send_req(REQ_LOOKUP, 32'd5255, 16'h0);     // fallback at full distance
        send_req(REQ_LOOKUP, 32'd4745, 16'h0);
        send_req(REQ_LOOKUP, 32'd5256, 16'h0);     // just past the window
        send_req(REQ_INSERT, 32'd1, 16'h0001);
        send_req(REQ_LOOKUP, 32'd2, 16'h0);        // below the window, no purge
        send_req(REQ_STATS, 32'd0, 16'h0);
    endtask

    // phases of mostly well-formed traffic around a moving base, with noise mixed in
    task automatic test_random_traffic();
        logic [DELTA_W-1:0] phase_skew [8];
        logic [SEQ_W-1:0]   base;
        int                 span;
        int                 pick;
        req_t               w;
        phase_skew = '{8'd0, 8'd255, 8'd3, 8'd1, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 16)), 8'd128, 8'($urandom_range(0, 255))};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_skew(phase_skew[ph]);
            burst_mode = ($urandom_range(0, 2) == 0);
            case (ph)
                2:       base = 32'hFFFF_FF00;      // near the top of the range
                3:       base = 32'h0000_0008;      // near zero
                default: base = $urandom;
            endcase
            span = int'(skew_cfg) + 4;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                w.payload_handle = 16'($urandom);
                if (pick < 40)
                begin
                    w.req_type = REQ_INSERT;
                    w.seq      = base - span + $urandom_range(0, 2 * span);
                    base       = base + $urandom_range(0, 3);
                end
                else if (pick < 75)
                begin
                    w.req_type = REQ_LOOKUP;
                    w.seq      = base - span + $urandom_range(0, 2 * span);
                end
                else if (pick < 82)
                begin
                    w.req_type = REQ_LOOKUP;
                    w.seq      = '0;
                end
                else if (pick < 88)
                begin
                    w.req_type = REQ_STATS;
                    w.seq      = $urandom;
                end
                else if (pick < 94)
                begin
                    // stray sequence anywhere in the range
                    w.req_type = ($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_LOOKUP;
                    w.seq      = $urandom;
                end
                else
                begin
                    w.req_type = 2'd3;
                    w.seq      = $urandom;
                end
                issue_word(w);
                // burst phases occasionally drop back to idle gaps for the rest of the phase
                if (burst_mode && $urandom_range(0, 19) == 0)
                    burst_mode = 1'b0;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_valid[i]  = 1'b0;
            ring_seq[i]    = '0;
            ring_handle[i] = '0;
        end
        ring_head    = 0;
        exact_cnt    = '0;
        fallback_cnt = '0;
        miss_cnt     = '0;
        skew_sum     = '0;
        skew_cfg     = MAX_SKEW_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_match_kinds();
        test_skew_window();
        test_random_traffic();

        // all owed words in, then room for anything stray
        wait_idle();
        repeat (40) @(posedge clk);

        $display("sent %0d request words (%0d with the unused code), checked %0d responses",
                 words_sent, words_dropped, rsp_checked);
        $display("max_skew written %0d times, zero and 255 among the settings",
                 skew_writes);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/skr_pkg.sv
hw/rtl/skr_ram.sv
hw/rtl/skr_ctrl.sv
hw/rtl/skr_dpath.sv
hw/rtl/seq_keyed_match_ring.sv
sim/tb.sv
